FILE: rtl/bdcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcd_pkg
// Shared constants and types for the button debounce and click detector.
// ----------------------------------------------------------------------------
package bdcd_pkg;

    // Width of the tick counter and of every timestamp
    localparam int TIME_WIDTH = 32;

    // Click count wraps back to one above this value
    localparam int MAX_CLICKS = 10;
    localparam int CLICK_WIDTH = $clog2(MAX_CLICKS + 2);

    // Configuration register widths
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int TICKS_WIDTH     = 16;
    localparam int TARGET_WIDTH    = 4;

    // Configuration register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ACTIVE_LOW   = 3'd0,
        CFG_DEBOUNCE     = 3'd1,
        CFG_LONG_PRESS   = 3'd2,
        CFG_CLICK_TARGET = 3'd3,
        CFG_CLICK_WINDOW = 3'd4
    } cfg_index_t;

    typedef logic [TIME_WIDTH-1:0]  time_t;
    typedef logic [CLICK_WIDTH-1:0] click_t;

    // Result of one tick
    typedef struct packed {
        logic stable_level;
        logic pressed_pulse;
        logic released_pulse;
        logic long_press;
        logic multi_click;
    } result_t;

endpackage

FILE: rtl/button_debounce_click_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_click_detector
// Debounces a raw button sample stream and reports press, release,
// long-press and multi-click events, one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the input channel (in_valid/in_ready, raw_level) is one
//   time tick. Every input transfer produces exactly one result transfer on
//   the output channel (out_valid/out_ready and the five event fields).
//   The result of an accepted item is registered and offered on the output
//   from the next cycle on.
//   Throughput is one item per cycle. The tick state update and the result
//   are computed in one pass of subtract-and-compare logic from the state
//   registers into the result register, so the next item is taken at once.
//   When the receiver stalls, the result register holds its item and
//   in_ready drops until that item leaves; the tick counter only advances
//   on accepted items, so stalls do not count as elapsed time.
//   Reset clears all timestamps, the click count and the output valid, and
//   loads the configuration defaults (active low, debounce 50, long press
//   1000, click target 2, click window 400). Configuration is written
//   through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// ----------------------------------------------------------------------------
module button_debounce_click_detector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [bdcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  logic [bdcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    // sample channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 raw_level,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 stable_level,
    output logic                                 pressed_pulse,
    output logic                                 released_pulse,
    output logic                                 long_press,
    output logic                                 multi_click
);
    import bdcd_pkg::*;

    // configuration registers
    logic                    active_low_reg;
    logic [TICKS_WIDTH-1:0]  debounce_reg;
    logic [TICKS_WIDTH-1:0]  long_press_reg;
    logic [TARGET_WIDTH-1:0] click_target_reg;
    logic [TICKS_WIDTH-1:0]  click_window_reg;

    // tick state
    time_t   tick_reg;
    logic    prev_sample_reg, prev_sample_next;
    time_t   change_time_reg, change_time_next;
    logic    level_reg, level_next;
    time_t   press_start_reg, press_start_next;
    time_t   last_click_reg, last_click_next;
    click_t  count_reg, count_next;

    // result register
    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic    accept;
    logic    sample;
    time_t   since_change;
    time_t   since_press;
    time_t   since_click;
    logic    press_event;
    logic    release_event;
    logic    hold_long;
    logic    click_quiet;
    logic    window_done;
    click_t  count_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg   <= 1'b1;
            debounce_reg     <= TICKS_WIDTH'(50);
            long_press_reg   <= TICKS_WIDTH'(1000);
            click_target_reg <= TARGET_WIDTH'(2);
            click_window_reg <= TICKS_WIDTH'(400);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ACTIVE_LOW:   active_low_reg   <= cfg_wdata[0];
                CFG_DEBOUNCE:     debounce_reg     <= cfg_wdata[TICKS_WIDTH-1:0];
                CFG_LONG_PRESS:   long_press_reg   <= cfg_wdata[TICKS_WIDTH-1:0];
                CFG_CLICK_TARGET: click_target_reg <= cfg_wdata[TARGET_WIDTH-1:0];
                CFG_CLICK_WINDOW: click_window_reg <= cfg_wdata[TICKS_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // debounce: a new sample level restarts the stability timer, so it
    // cannot pass on the tick it changes
    always_comb
    begin
        sample           = raw_level ^ active_low_reg;
        prev_sample_next = sample;
        change_time_next = (sample != prev_sample_reg) ? tick_reg : change_time_reg;
        since_change     = tick_reg - change_time_reg;
        press_event      = 1'b0;
        release_event    = 1'b0;
        if ((sample == prev_sample_reg) && (since_change > TIME_WIDTH'(debounce_reg))
            && (sample != level_reg))
        begin
            press_event   = sample;
            release_event = !sample;
        end
        level_next = (press_event || release_event) ? sample : level_reg;
    end

    // press stamps and click counting; a press this tick means zero elapsed
    always_comb
    begin
        count_inc        = count_reg + click_t'(1);
        press_start_next = press_event ? tick_reg : press_start_reg;
        last_click_next  = press_event ? tick_reg : last_click_reg;
        since_press      = tick_reg - press_start_reg;
        since_click      = tick_reg - last_click_reg;
        hold_long        = press_event ? (long_press_reg == '0)
                                       : (since_press >= TIME_WIDTH'(long_press_reg));
        click_quiet      = press_event ? (click_window_reg == '0)
                                       : (since_click >= TIME_WIDTH'(click_window_reg));
        count_next       = count_reg;
        if (press_event)
        begin
            count_next = (count_inc > click_t'(MAX_CLICKS)) ? click_t'(1) : count_inc;
        end
        window_done = (count_next != '0)
                   && click_quiet
                   && (CLICK_WIDTH'(click_target_reg) == count_next);
        if (window_done)
        begin
            count_next = '0;
        end
    end

    // result of this tick
    always_comb
    begin
        result_next.stable_level   = level_next;
        result_next.pressed_pulse  = press_event;
        result_next.released_pulse = release_event;
        result_next.long_press     = level_next && hold_long;
        result_next.multi_click    = window_done;
    end

    // tick state update on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            prev_sample_reg <= 1'b0;
            change_time_reg <= '0;
            level_reg       <= 1'b0;
            press_start_reg <= '0;
            last_click_reg  <= '0;
            count_reg       <= '0;
        end
        else if (accept)
        begin
            tick_reg        <= tick_reg + time_t'(1);
            prev_sample_reg <= prev_sample_next;
            change_time_reg <= change_time_next;
            level_reg       <= level_next;
            press_start_reg <= press_start_next;
            last_click_reg  <= last_click_next;
            count_reg       <= count_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // output payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stable_level   = result_reg.stable_level;
    assign pressed_pulse  = result_reg.pressed_pulse;
    assign released_pulse = result_reg.released_pulse;
    assign long_press     = result_reg.long_press;
    assign multi_click    = result_reg.multi_click;

endmodule

FILE: rtl/bdcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcd_checker
// Port-level checks for the button debounce and click detector.
// ----------------------------------------------------------------------------
module bdcd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic stable_level,
    input logic pressed_pulse,
    input logic released_pulse,
    input logic long_press,
    input logic multi_click
);

    // stalled result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stable_level)
            && $stable(pressed_pulse) && $stable(released_pulse)
            && $stable(long_press) && $stable(multi_click))
        else $error("stalled result changed");

    // an empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // one input transfer gives one result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("result missing after input transfer");

    // edge pulses agree with the debounced level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pressed_pulse && !stable_level)
            && !(released_pulse && stable_level))
        else $error("edge pulse disagrees with level");

    // long press only while pressed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && long_press |-> stable_level)
        else $error("long press while released");

endmodule

bind button_debounce_click_detector bdcd_checker u_bdcd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stable_level   (stable_level),
    .pressed_pulse  (pressed_pulse),
    .released_pulse (released_pulse),
    .long_press     (long_press),
    .multi_click    (multi_click)
);
